>>> design/b58_pkg.sv
// ----------------------------------------------------------------------------
// b58_pkg: shared types, constants and the symbol lookup
// Holds the alphabet, the cell widths and the control bundle for the drain
// cells of the base58 address hash decoder.
// ----------------------------------------------------------------------------
package b58_pkg;

  localparam int BYTE_W         = 8;
  localparam int ACC_BYTES      = 24;  // 192-bit accumulator, one byte per cell
  localparam int HASH_BYTES_DEF = 20;
  localparam int RADIX          = 58;
  localparam int DIGIT_W        = 6;
  localparam int CARRY_W        = 7;   // pending carry never exceeds 74
  localparam int PROD_W         = 15;  // (255 + 74) * 58 + 57 fits in 15 bits

  localparam logic [8*RADIX-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] value;
  } sym_digit_t;

  typedef struct packed {
    logic load;
    logic resolve;
    logic shift;
  } drain_ctl_t;

  // Maps an ASCII code to its digit. Codes outside the alphabet give digit 0
  // with ok cleared.
  function automatic sym_digit_t digit_of(input logic [BYTE_W-1:0] code);
    sym_digit_t res;
    res.ok    = 1'b0;
    res.value = '0;
    for (int k = 0; k < RADIX; k++) begin
      if (code == ALPHABET[BYTE_W*(RADIX-1-k) +: BYTE_W]) begin
        res.ok    = 1'b1;
        res.value = DIGIT_W'(k);
      end
    end
    return res;
  endfunction

endpackage

>>> design/b58_acc_cell.sv
// ----------------------------------------------------------------------------
// b58_acc_cell: one byte of the carry-save accumulator
// Each cell multiplies its byte plus the carry from the cell below by the
// radix and keeps the low byte, passing the rest up as a registered carry.
// ----------------------------------------------------------------------------
module b58_acc_cell
  import b58_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               clear,
  input  logic [DIGIT_W-1:0] digit_in,
  input  logic [CARRY_W-1:0] carry_in,
  output logic [BYTE_W-1:0]  byte_q,
  output logic [CARRY_W-1:0] carry_q,
  output logic [BYTE_W-1:0]  byte_nxt,
  output logic [CARRY_W-1:0] carry_nxt
);

  logic [BYTE_W-1:0]  byte_r;
  logic [CARRY_W-1:0] carry_r;
  logic [BYTE_W:0]    sum;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    sum       = {1'b0, byte_r} + {2'b00, carry_in};
    prod      = PROD_W'(sum) * PROD_W'(RADIX) + PROD_W'(digit_in);
    byte_nxt  = prod[BYTE_W-1:0];
    carry_nxt = prod[PROD_W-1:BYTE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      carry_r <= '0;
    end else if (step) begin
      if (clear) begin
        byte_r  <= '0;
        carry_r <= '0;
      end else begin
        byte_r  <= byte_nxt;
        carry_r <= carry_nxt;
      end
    end
  end

  assign byte_q  = byte_r;
  assign carry_q = carry_r;

endmodule

>>> design/b58_drain_cell.sv
// ----------------------------------------------------------------------------
// b58_drain_cell: one byte of the result buffer
// Loads a byte and its pending carry, settles the carry one position per
// cycle, and then shifts the byte toward the top cell for output.
// ----------------------------------------------------------------------------
module b58_drain_cell
  import b58_pkg::*;
(
  input  logic               clk,
  input  drain_ctl_t         ctl,
  input  logic [BYTE_W-1:0]  load_byte,
  input  logic [CARRY_W-1:0] load_carry,
  input  logic [CARRY_W-1:0] carry_in,
  input  logic [BYTE_W-1:0]  shift_in,
  output logic [BYTE_W-1:0]  byte_q,
  output logic [CARRY_W-1:0] carry_q
);

  logic [BYTE_W-1:0]  byte_r,  byte_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [BYTE_W:0]    sum;

  always_comb begin
    sum       = {1'b0, byte_r} + {2'b00, carry_in};
    byte_nxt  = byte_r;
    carry_nxt = carry_r;
    if (ctl.load) begin
      byte_nxt  = load_byte;
      carry_nxt = load_carry;
    end else if (ctl.resolve) begin
      byte_nxt  = sum[BYTE_W-1:0];
      carry_nxt = CARRY_W'(sum[BYTE_W]);
    end else if (ctl.shift) begin
      byte_nxt  = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    carry_r <= carry_nxt;
  end

  assign byte_q  = byte_r;
  assign carry_q = carry_r;

endmodule

>>> design/base58_address_hash_decoder.sv
// ----------------------------------------------------------------------------
// base58_address_hash_decoder: streaming base58 address to hash bytes
// Accumulates address characters and delivers the public key hash bytes.
// ----------------------------------------------------------------------------
// Characters enter one word per cycle; each is looked up in the base58
// alphabet and folded into a 192-bit value as value*58+digit by a row of
// 24 byte cells that keep their carries in registers, so no carry ever
// ripples through more than one cell in a cycle. The character marked last
// copies the cells into a second row of byte cells, which settles the pending
// carries one position per cycle, until no carry is left below the top cell,
// and then shifts the bytes out most significant first,
// HASH_BYTES words in all, one per cycle while the output is not stalled.
// The accumulator is cleared on that same cycle and takes the next address
// at once. Characters that are not marked last are never stalled; a last
// character is stalled only while the previous address's bytes are still
// settling or draining. An address of at least 24 + HASH_BYTES characters
// (44 with the default) never waits while the output keeps up; shorter
// addresses, typical ones included, may wait at their last character.
// A character outside the alphabet counts as digit 0 and raises bad_char on
// every word of that address. The checksum is not verified.
// ----------------------------------------------------------------------------
module base58_address_hash_decoder
  import b58_pkg::*;
#(
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_char_code,
  input  logic              in_last_char,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_hash_byte,
  output logic              out_last_byte,
  output logic              out_bad_char
);

  localparam int CNT_W = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RESOLVE,
    D_EMIT
  } drain_state_t;

  drain_state_t dstate_r;
  logic [CNT_W-1:0] cnt_r;
  logic             bad_r;
  logic             err_r;

  sym_digit_t   sym;
  logic         step;
  logic         load;
  logic         load_ok;
  logic         out_fire;
  logic         last_pos;
  logic         pending;
  logic         acc_zero;
  drain_ctl_t   dctl;

  logic [BYTE_W-1:0]  acc_byte      [ACC_BYTES];
  logic [CARRY_W-1:0] acc_carry     [ACC_BYTES];
  logic [BYTE_W-1:0]  acc_byte_nxt  [ACC_BYTES];
  logic [CARRY_W-1:0] acc_carry_nxt [ACC_BYTES];
  logic [CARRY_W-1:0] acc_cin       [ACC_BYTES];
  logic [DIGIT_W-1:0] acc_din       [ACC_BYTES];

  logic [BYTE_W-1:0]  dr_byte  [ACC_BYTES];
  logic [CARRY_W-1:0] dr_carry [ACC_BYTES];
  logic [CARRY_W-1:0] dr_cin   [ACC_BYTES];
  logic [BYTE_W-1:0]  dr_sin   [ACC_BYTES];

  // Symbol lookup and the input handshake. A last character needs the
  // result buffer, which is free when idle or when its final word leaves.
  assign sym      = digit_of(in_char_code);
  assign out_fire = out_valid && !out_stall;
  assign last_pos = (cnt_r == CNT_W'(HASH_BYTES - 1));
  assign load_ok  = (dstate_r == D_IDLE) || (dstate_r == D_EMIT && out_fire && last_pos);
  assign in_stall = in_last_char && !load_ok;
  assign step     = in_valid && !in_stall;
  assign load     = step && in_last_char;

  // Neighbor wiring: each cell sees the registered carry of the cell below,
  // and only the bottom cell receives the new digit.
  always_comb begin
    for (int i = 0; i < ACC_BYTES; i++) begin
      acc_din[i] = '0;
      acc_cin[i] = '0;
      dr_cin[i]  = '0;
      dr_sin[i]  = '0;
      if (i == 0) begin
        acc_din[i] = sym.value;
      end else begin
        acc_cin[i] = acc_carry[i-1];
        dr_cin[i]  = dr_carry[i-1];
        dr_sin[i]  = dr_byte[i-1];
      end
    end
  end

  // The result is settled once no carry is left waiting below the top cell;
  // the top cell's carry falls outside the 192-bit value.
  always_comb begin
    pending  = 1'b0;
    acc_zero = 1'b1;
    for (int i = 0; i < ACC_BYTES; i++) begin
      if (i < ACC_BYTES - 1 && dr_carry[i] != '0) begin
        pending = 1'b1;
      end
      if (acc_byte[i] != '0 || acc_carry[i] != '0) begin
        acc_zero = 1'b0;
      end
    end
  end

  always_comb begin
    dctl.load    = load;
    dctl.resolve = (dstate_r == D_RESOLVE) && pending;
    dctl.shift   = (dstate_r == D_EMIT) && out_fire && !load;
  end

  for (genvar g = 0; g < ACC_BYTES; g++) begin : g_cells
    b58_acc_cell u_acc (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (step),
      .clear     (in_last_char),
      .digit_in  (acc_din[g]),
      .carry_in  (acc_cin[g]),
      .byte_q    (acc_byte[g]),
      .carry_q   (acc_carry[g]),
      .byte_nxt  (acc_byte_nxt[g]),
      .carry_nxt (acc_carry_nxt[g])
    );

    b58_drain_cell u_drain (
      .clk        (clk),
      .ctl        (dctl),
      .load_byte  (acc_byte_nxt[g]),
      .load_carry (acc_carry_nxt[g]),
      .carry_in   (dr_cin[g]),
      .shift_in   (dr_sin[g]),
      .byte_q     (dr_byte[g]),
      .carry_q    (dr_carry[g])
    );
  end

  // Error flag for the address in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= 1'b0;
    end else if (step) begin
      if (in_last_char) begin
        err_r <= 1'b0;
      end else begin
        err_r <= err_r || !sym.ok;
      end
    end
  end

  // Result buffer sequencer: settle carries, then count the words out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      cnt_r    <= '0;
      bad_r    <= 1'b0;
    end else begin
      case (dstate_r)
        D_IDLE: begin
          if (load) begin
            dstate_r <= D_RESOLVE;
            bad_r    <= err_r || !sym.ok;
          end
        end
        D_RESOLVE: begin
          if (!pending) begin
            dstate_r <= D_EMIT;
            cnt_r    <= '0;
          end
        end
        D_EMIT: begin
          if (out_fire) begin
            cnt_r <= cnt_r + 1'b1;
            if (last_pos) begin
              if (load) begin
                dstate_r <= D_RESOLVE;
                bad_r    <= err_r || !sym.ok;
              end else begin
                dstate_r <= D_IDLE;
              end
            end
          end
        end
        default: begin
          dstate_r <= D_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = (dstate_r == D_EMIT);
  assign out_hash_byte = dr_byte[ACC_BYTES-1];
  assign out_last_byte = last_pos;
  assign out_bad_char  = bad_r;

  // Bytes go out only once every carry below the top has been absorbed.
  a_settled_when_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (dstate_r == D_EMIT) |-> !pending)
    else $error("result word presented with unsettled carries");

  // An accepted last character always starts a settling pass.
  a_load_starts_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_char) |=> (dstate_r == D_RESOLVE))
    else $error("last character did not start the result buffer");

  // The accumulator is empty after the last character of an address.
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_char) |=> acc_zero)
    else $error("accumulator not cleared after last character");

  // No further words follow the final word of a result.
  a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_byte) |=> (dstate_r != D_EMIT))
    else $error("result words continued after the final word");

endmodule
